// ----- rtl/scheduled_clock_controller_defines.svh -----
// Assertion macros for the scheduled clock controller checkers.
`ifndef SCHEDULED_CLOCK_CONTROLLER_DEFINES_SVH
`define SCHEDULED_CLOCK_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SCC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define SCC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/scc_pkg.sv -----
package scc_pkg;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_HOUR   = 2'd1,
    REQ_MINUTE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    REG_HEAT_THRESHOLD = 2'd0,
    REG_HEAT_PERSIST   = 2'd1,
    REG_MEASURE_PERIOD = 2'd2,
    REG_RAMP_INTERVAL  = 2'd3
  } reg_idx_t;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [9:0] THRESHOLD_RST = 10'd44;
  localparam logic [7:0] PERSIST_RST   = 8'd30;
  localparam logic [7:0] PERIOD_RST    = 8'd30;
  localparam logic [7:0] RAMP_RST      = 8'd7;

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  localparam logic [4:0] MORNING_HOUR = 5'd7;
  localparam logic [4:0] EVENING_HOUR = 5'd20;
  localparam logic [5:0] RAMP_END_MIN = 6'd30;

  localparam logic [7:0] DUTY_DOWN_MIN = 8'd6;
  localparam logic [7:0] DUTY_ZERO_MAX = 8'd7;
  localparam logic [7:0] DUTY_UP_MAX   = 8'd249;
  localparam logic [7:0] DUTY_FULL_MIN = 8'd250;
  localparam logic [7:0] DUTY_FULL     = 8'd255;
  localparam logic [7:0] COUNT_MAX     = 8'd255;

  localparam logic [4:0] L1_ON_H  = 5'd7;
  localparam logic [5:0] L1_ON_M  = 6'd30;
  localparam logic [4:0] L1_OFF_H = 5'd19;
  localparam logic [5:0] L1_OFF_M = 6'd0;
  localparam logic [4:0] L2_ON_H  = 5'd8;
  localparam logic [5:0] L2_ON_M  = 6'd0;
  localparam logic [4:0] L2_OFF_H = 5'd19;
  localparam logic [5:0] L2_OFF_M = 6'd30;
  localparam logic [4:0] L3_ON_H  = 5'd8;
  localparam logic [5:0] L3_ON_M  = 6'd30;
  localparam logic [4:0] L3_OFF_H = 5'd20;
  localparam logic [5:0] L3_OFF_M = 6'd0;

  typedef struct packed {
    logic [9:0] heat_threshold_code;
    logic [7:0] heat_persistence;
    logic [7:0] measure_period;
    logic [7:0] ramp_interval;
  } cfg_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] lights;
    logic       heater_on;
    logic [7:0] led_duty;
    logic [9:0] temperature_code;
  } res_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

// ----- rtl/scc_cfg.sv -----
module scc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scc_pkg::ADDR_W-1:0] paddr,
  input  logic [scc_pkg::DATA_W-1:0] pwdata,
  output logic [scc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output scc_pkg::cfg_t              cfg
);
  import scc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heat_threshold_code <= THRESHOLD_RST;
      cfg_r.heat_persistence    <= PERSIST_RST;
      cfg_r.measure_period      <= PERIOD_RST;
      cfg_r.ramp_interval       <= RAMP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_HEAT_THRESHOLD: cfg_r.heat_threshold_code <= pwdata[9:0];
        REG_HEAT_PERSIST:   cfg_r.heat_persistence    <= pwdata[7:0];
        REG_MEASURE_PERIOD: cfg_r.measure_period      <= pwdata[7:0];
        REG_RAMP_INTERVAL:  cfg_r.ramp_interval       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEAT_THRESHOLD: prdata = {22'd0, cfg_r.heat_threshold_code};
      REG_HEAT_PERSIST:   prdata = {24'd0, cfg_r.heat_persistence};
      REG_MEASURE_PERIOD: prdata = {24'd0, cfg_r.measure_period};
      REG_RAMP_INTERVAL:  prdata = {24'd0, cfg_r.ramp_interval};
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- rtl/scc_core.sv -----
module scc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [1:0]    req_type,
  input  logic [9:0]    adc_sample,
  input  scc_pkg::cfg_t cfg,
  output scc_pkg::res_t res
);
  import scc_pkg::*;

  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [9:0] held_r, held_nxt;
  logic [7:0] meas_cnt_r, meas_cnt_nxt;
  logic       heater_r, heater_nxt;
  logic [7:0] heat_cnt_r, heat_cnt_nxt;
  logic [7:0] ramp_cnt_r, ramp_cnt_nxt;
  logic [7:0] duty_r, duty_nxt;
  logic [2:0] lights_r, lights_nxt;

  logic cold;
  logic morning;
  logic evening;
  req_t req;

  assign req = req_t'(req_type);

  always_comb begin
    sec_nxt      = sec_r;
    min_nxt      = min_r;
    hour_nxt     = hour_r;
    held_nxt     = held_r;
    meas_cnt_nxt = meas_cnt_r;
    heater_nxt   = heater_r;
    heat_cnt_nxt = heat_cnt_r;
    ramp_cnt_nxt = ramp_cnt_r;
    duty_nxt     = duty_r;
    lights_nxt   = lights_r;
    cold         = held_r <= cfg.heat_threshold_code;
    morning      = 1'b0;
    evening      = 1'b0;

    case (req)
      REQ_TICK: begin
        if (sec_r >= SEC_MAX) begin
          sec_nxt = '0;
          if (min_r >= MIN_MAX) begin
            min_nxt  = '0;
            hour_nxt = (hour_r >= HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
          end else begin
            min_nxt = min_r + 6'd1;
          end
        end else begin
          sec_nxt = sec_r + 6'd1;
        end

        meas_cnt_nxt = sat_inc(meas_cnt_r);

        // heater: count ticks that disagree with the current level
        heat_cnt_nxt = (cold != heater_r) ? sat_inc(heat_cnt_r) : 8'd0;
        if (heat_cnt_nxt >= cfg.heat_persistence) begin
          heat_cnt_nxt = '0;
          heater_nxt   = ~heater_r;
        end

        morning = (hour_nxt == MORNING_HOUR) && (min_nxt <= RAMP_END_MIN);
        evening = (hour_nxt == EVENING_HOUR) && (min_nxt <= RAMP_END_MIN);
        if (morning) begin
          ramp_cnt_nxt = sat_inc(ramp_cnt_r);
          if (ramp_cnt_nxt >= cfg.ramp_interval && duty_r >= DUTY_DOWN_MIN) begin
            duty_nxt     = duty_r - 8'd1;
            ramp_cnt_nxt = '0;
          end
          if (duty_nxt <= DUTY_ZERO_MAX) duty_nxt = '0;
        end
        if (evening) begin
          ramp_cnt_nxt = sat_inc(ramp_cnt_r);
          if (ramp_cnt_nxt >= cfg.ramp_interval && duty_r <= DUTY_UP_MAX) begin
            duty_nxt     = duty_r + 8'd1;
            ramp_cnt_nxt = '0;
          end
          if (duty_nxt >= DUTY_FULL_MIN) duty_nxt = DUTY_FULL;
        end

        if (meas_cnt_nxt >= cfg.measure_period) begin
          held_nxt     = adc_sample;
          meas_cnt_nxt = '0;
        end
      end
      REQ_HOUR:   hour_nxt = (hour_r >= HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
      REQ_MINUTE: min_nxt  = (min_r >= MIN_MAX) ? 6'd0 : min_r + 6'd1;
      default: ;
    endcase

    if (hour_nxt == L1_ON_H  && min_nxt == L1_ON_M)  lights_nxt[0] = 1'b1;
    if (hour_nxt == L1_OFF_H && min_nxt == L1_OFF_M) lights_nxt[0] = 1'b0;
    if (hour_nxt == L2_ON_H  && min_nxt == L2_ON_M)  lights_nxt[1] = 1'b1;
    if (hour_nxt == L2_OFF_H && min_nxt == L2_OFF_M) lights_nxt[1] = 1'b0;
    if (hour_nxt == L3_ON_H  && min_nxt == L3_ON_M)  lights_nxt[2] = 1'b1;
    if (hour_nxt == L3_OFF_H && min_nxt == L3_OFF_M) lights_nxt[2] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r      <= '0;
      min_r      <= '0;
      hour_r     <= '0;
      held_r     <= '0;
      meas_cnt_r <= '0;
      heater_r   <= 1'b0;
      heat_cnt_r <= '0;
      ramp_cnt_r <= '0;
      duty_r     <= DUTY_FULL;
      lights_r   <= '0;
    end else if (load) begin
      sec_r      <= sec_nxt;
      min_r      <= min_nxt;
      hour_r     <= hour_nxt;
      held_r     <= held_nxt;
      meas_cnt_r <= meas_cnt_nxt;
      heater_r   <= heater_nxt;
      heat_cnt_r <= heat_cnt_nxt;
      ramp_cnt_r <= ramp_cnt_nxt;
      duty_r     <= duty_nxt;
      lights_r   <= lights_nxt;
    end
  end

  assign res.hours            = hour_r;
  assign res.minutes          = min_r;
  assign res.seconds          = sec_r;
  assign res.lights           = lights_r;
  assign res.heater_on        = heater_r;
  assign res.led_duty         = duty_r;
  assign res.temperature_code = held_r;

endmodule

// ----- rtl/scheduled_clock_controller.sv -----
// An accepted input passes the input register, then the state/result register, after which
// out_valid rises. Throughput: one transaction per cycle unless a valid result is stalled;
// the result register is the clock and control state. in_stall rises only when a registered
// transaction waits behind a stalled result.
// Reset (synchronous, rst_n low): pipeline empty, time 00:00:00, heater off, lights off,
// LED duty 255, held code 0, registers back to their defaults (44, 30, 30, 7).
module scheduled_clock_controller (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [9:0]                 in_adc_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [4:0]                 out_hours,
  output logic [5:0]                 out_minutes,
  output logic [5:0]                 out_seconds,
  output logic                       out_light_one,
  output logic                       out_light_two,
  output logic                       out_light_three,
  output logic                       out_heater_on,
  output logic [7:0]                 out_led_duty,
  output logic [9:0]                 out_temperature_code,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scc_pkg::ADDR_W-1:0] paddr,
  input  logic [scc_pkg::DATA_W-1:0] pwdata,
  output logic [scc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import scc_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       stg_valid_r;
  logic [1:0] stg_req_r;
  logic [9:0] stg_sample_r;
  logic       out_valid_r;
  logic       in_take;
  logic       load;

  assign load     = stg_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = stg_valid_r & ~load;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take)   stg_valid_r <= 1'b1;
      else if (load) stg_valid_r <= 1'b0;
      if (load)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_req_r    <= in_req_type;
      stg_sample_r <= in_adc_sample;
    end
  end

  scc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .req_type   (stg_req_r),
    .adc_sample (stg_sample_r),
    .cfg        (cfg),
    .res        (res)
  );

  assign out_valid            = out_valid_r;
  assign out_hours            = res.hours;
  assign out_minutes          = res.minutes;
  assign out_seconds          = res.seconds;
  assign out_light_one        = res.lights[0];
  assign out_light_two        = res.lights[1];
  assign out_light_three      = res.lights[2];
  assign out_heater_on        = res.heater_on;
  assign out_led_duty         = res.led_duty;
  assign out_temperature_code = res.temperature_code;

endmodule

// ----- rtl/scc_checker.sv -----
`include "scheduled_clock_controller_defines.svh"

module scc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] out_hours,
  input logic [5:0] out_minutes,
  input logic [5:0] out_seconds,
  input logic       out_light_one,
  input logic       out_light_three,
  input logic [7:0] out_led_duty
);
  import scc_pkg::*;

  `SCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hours) && $stable(out_minutes) && $stable(out_seconds) && $stable(out_led_duty))
  `SCC_ASSERT_IMPL(a_time_range, out_valid, out_hours <= HOUR_MAX && out_minutes <= MIN_MAX && out_seconds <= SEC_MAX)
  `SCC_ASSERT_IMPL(a_light_one_on, out_valid && out_hours == L1_ON_H && out_minutes == L1_ON_M, out_light_one)
  `SCC_ASSERT_IMPL(a_light_three_off, out_valid && out_hours == L3_OFF_H && out_minutes == L3_OFF_M, !out_light_three)

endmodule

bind scheduled_clock_controller scc_checker u_scc_checker (.*);
